// ===== design/csl_pkg.sv =====
// Shared types and constants of the command safety limiter.
`default_nettype none
package csl_pkg;

  localparam int unsigned CmdWidth  = 16;
  localparam int unsigned StepWidth = 15;
  localparam int unsigned AgeWidth  = 32;
  localparam int unsigned TimeWidth = 64;
  localparam int unsigned CfgDataWidth = 32;

  typedef enum logic [1:0] {
    OUT_PASSED   = 2'd0,
    OUT_FALLBACK = 2'd1,
    OUT_HALT     = 2'd2
  } outcome_t;

  typedef enum logic [2:0] {
    CODE_NONE    = 3'd0,
    CODE_T_RANGE = 3'd1,
    CODE_S_RANGE = 3'd2,
    CODE_STALE   = 3'd3,
    CODE_T_RATE  = 3'd4,
    CODE_S_RATE  = 3'd5
  } viol_code_t;

  typedef enum logic [2:0] {
    REG_T_LOW    = 3'd0,
    REG_T_HIGH   = 3'd1,
    REG_S_LOW    = 3'd2,
    REG_S_HIGH   = 3'd3,
    REG_T_STEP   = 3'd4,
    REG_S_STEP   = 3'd5,
    REG_MAX_AGE  = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic signed [CmdWidth-1:0] t_low;
    logic signed [CmdWidth-1:0] t_high;
    logic signed [CmdWidth-1:0] s_low;
    logic signed [CmdWidth-1:0] s_high;
    logic [StepWidth-1:0]       t_step;
    logic [StepWidth-1:0]       s_step;
    logic [AgeWidth-1:0]        max_age;
  } cfg_t;

  typedef struct packed {
    logic signed [CmdWidth-1:0] throttle;
    logic signed [CmdWidth-1:0] steering;
    logic                       valid;
  } ref_state_t;

  typedef struct packed {
    outcome_t                   outcome;
    viol_code_t                 code;
    logic signed [CmdWidth-1:0] throttle;
    logic signed [CmdWidth-1:0] steering;
    logic                       update;
  } check_res_t;

endpackage
`default_nettype wire

// ===== design/command_safety_limiter_unit.sv =====
// Top level of the command safety limiter: input register, checks, result register.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------------
//  in       | in_valid / in_ready   | throttle_in, steering_in, command_time, current_time
//  out      | out_valid / out_ready | outcome, violation_code, throttle_out, steering_out
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A command lands in the input register, where the checks run; as it advances, the
// result register loads, with the reference state unless it halts or is stale.
// One command per cycle sustained while the output is not stalled. The reference state
// update is the loop that sets the rate. Reset restores the default limits and clears
// the reference. A stall holds each full stage; cfg_ready is always high.
`default_nettype none
module command_safety_limiter_unit
  import csl_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [CmdWidth-1:0]  throttle_in,
  input  wire logic signed [CmdWidth-1:0]  steering_in,
  input  wire logic [TimeWidth-1:0]        command_time,
  input  wire logic [TimeWidth-1:0]        current_time,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       outcome,
  output logic [2:0]                       violation_code,
  output logic signed [CmdWidth-1:0]       throttle_out,
  output logic signed [CmdWidth-1:0]       steering_out,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [2:0]                  cfg_index,
  input  wire logic [CfgDataWidth-1:0]     cfg_data
);

  cfg_t                       cfg;
  ref_state_t                 prev;
  check_res_t                 res;
  logic                       s1_valid;
  logic signed [CmdWidth-1:0] s1_throttle;
  logic signed [CmdWidth-1:0] s1_steering;
  logic [TimeWidth-1:0]       s1_cmd_time;
  logic [TimeWidth-1:0]       s1_now;
  logic                       advance;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;

  csl_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  csl_check u_check (
    .cfg      (cfg),
    .prev     (prev),
    .throttle (s1_throttle),
    .steering (s1_steering),
    .cmd_time (s1_cmd_time),
    .now      (s1_now),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_throttle <= throttle_in;
      s1_steering <= steering_in;
      s1_cmd_time <= command_time;
      s1_now      <= current_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      outcome        <= res.outcome;
      violation_code <= res.code;
      throttle_out   <= res.throttle;
      steering_out   <= res.steering;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
    end else if (advance && res.update) begin
      prev.throttle <= res.throttle;
      prev.steering <= res.steering;
      prev.valid    <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== design/csl_cfg_regs.sv =====
// Configuration register file of the command safety limiter.
`default_nettype none
module csl_cfg_regs
  import csl_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    wr_en,
  input  wire logic [2:0]              wr_index,
  input  wire logic [CfgDataWidth-1:0] wr_data,
  output cfg_t                         cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.t_low   <= -16'sd8192;
      cfg.t_high  <= 16'sd8192;
      cfg.s_low   <= -16'sd8192;
      cfg.s_high  <= 16'sd8192;
      cfg.t_step  <= 15'd819;
      cfg.s_step  <= 15'd819;
      cfg.max_age <= 32'd200000;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_T_LOW:   cfg.t_low   <= wr_data[CmdWidth-1:0];
        REG_T_HIGH:  cfg.t_high  <= wr_data[CmdWidth-1:0];
        REG_S_LOW:   cfg.s_low   <= wr_data[CmdWidth-1:0];
        REG_S_HIGH:  cfg.s_high  <= wr_data[CmdWidth-1:0];
        REG_T_STEP:  cfg.t_step  <= wr_data[StepWidth-1:0];
        REG_S_STEP:  cfg.s_step  <= wr_data[StepWidth-1:0];
        REG_MAX_AGE: cfg.max_age <= wr_data[AgeWidth-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/csl_check.sv =====
// Range, staleness and rate checks with step-window clamping.
`default_nettype none
module csl_check
  import csl_pkg::*;
(
  input  wire cfg_t                         cfg,
  input  wire ref_state_t                   prev,
  input  wire logic signed [CmdWidth-1:0]   throttle,
  input  wire logic signed [CmdWidth-1:0]   steering,
  input  wire logic [TimeWidth-1:0]         cmd_time,
  input  wire logic [TimeWidth-1:0]         now,
  output check_res_t                        res
);

  logic                           t_range_bad;
  logic                           s_range_bad;
  logic                           stale;
  logic [TimeWidth-1:0]           age;
  logic signed [CmdWidth:0]       t_diff;
  logic signed [CmdWidth:0]       s_diff;
  logic [CmdWidth:0]              t_mag;
  logic [CmdWidth:0]              s_mag;
  logic                           t_rate_bad;
  logic                           s_rate_bad;
  logic signed [CmdWidth+1:0]     t_val;
  logic signed [CmdWidth+1:0]     s_val;
  logic signed [CmdWidth+1:0]     t_lo;
  logic signed [CmdWidth+1:0]     t_hi;
  logic signed [CmdWidth+1:0]     s_lo;
  logic signed [CmdWidth+1:0]     s_hi;
  logic signed [CmdWidth+1:0]     t_clamp;
  logic signed [CmdWidth+1:0]     s_clamp;

  assign t_range_bad = (throttle < cfg.t_low) || (throttle > cfg.t_high);
  assign s_range_bad = (steering < cfg.s_low) || (steering > cfg.s_high);

  assign age   = now - cmd_time;
  assign stale = (cmd_time != '0) && (now > cmd_time) &&
                 (age > {{(TimeWidth-AgeWidth){1'b0}}, cfg.max_age});

  assign t_diff = {throttle[CmdWidth-1], throttle} - {prev.throttle[CmdWidth-1], prev.throttle};
  assign s_diff = {steering[CmdWidth-1], steering} - {prev.steering[CmdWidth-1], prev.steering};
  assign t_mag  = t_diff[CmdWidth] ? 17'(-t_diff) : t_diff;
  assign s_mag  = s_diff[CmdWidth] ? 17'(-s_diff) : s_diff;
  assign t_rate_bad = t_mag >= {2'b00, cfg.t_step};
  assign s_rate_bad = s_mag >= {2'b00, cfg.s_step};

  assign t_val = {{2{throttle[CmdWidth-1]}}, throttle};
  assign s_val = {{2{steering[CmdWidth-1]}}, steering};
  assign t_lo  = {{2{prev.throttle[CmdWidth-1]}}, prev.throttle} - {3'b000, cfg.t_step};
  assign t_hi  = {{2{prev.throttle[CmdWidth-1]}}, prev.throttle} + {3'b000, cfg.t_step};
  assign s_lo  = {{2{prev.steering[CmdWidth-1]}}, prev.steering} - {3'b000, cfg.s_step};
  assign s_hi  = {{2{prev.steering[CmdWidth-1]}}, prev.steering} + {3'b000, cfg.s_step};
  assign t_clamp = (t_val < t_lo) ? t_lo : ((t_val > t_hi) ? t_hi : t_val);
  assign s_clamp = (s_val < s_lo) ? s_lo : ((s_val > s_hi) ? s_hi : s_val);

  always_comb begin
    res.outcome  = OUT_PASSED;
    res.code     = CODE_NONE;
    res.throttle = throttle;
    res.steering = steering;
    res.update   = 1'b1;
    if (t_range_bad || s_range_bad) begin
      res.outcome  = OUT_HALT;
      res.code     = t_range_bad ? CODE_T_RANGE : CODE_S_RANGE;
      res.throttle = '0;
      res.steering = '0;
      res.update   = 1'b0;
    end else if (stale) begin
      res.outcome  = OUT_FALLBACK;
      res.code     = CODE_STALE;
      res.throttle = '0;
      res.steering = '0;
      res.update   = 1'b0;
    end else if (prev.valid && (t_rate_bad || s_rate_bad)) begin
      res.outcome  = OUT_FALLBACK;
      res.code     = t_rate_bad ? CODE_T_RATE : CODE_S_RATE;
      res.throttle = t_clamp[CmdWidth-1:0];
      res.steering = s_clamp[CmdWidth-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== design/csl_checker.sv =====
// Port-level assertions for the command safety limiter, bound to the top level.
`default_nettype none
module csl_checker
  import csl_pkg::*;
(
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [1:0]                 outcome,
  input wire logic [2:0]                 violation_code,
  input wire logic signed [CmdWidth-1:0] throttle_out,
  input wire logic signed [CmdWidth-1:0] steering_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(outcome) &&
      $stable(violation_code) && $stable(throttle_out) && $stable(steering_out))
    else $error("result changed while stalled");

  a_range_halts: assert property (@(posedge clk) disable iff (rst)
    out_valid && (violation_code == CODE_T_RANGE || violation_code == CODE_S_RANGE) |->
      outcome == OUT_HALT && throttle_out == '0 && steering_out == '0)
    else $error("range violation without zeroed halt");

  a_stale_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && violation_code == CODE_STALE |->
      outcome == OUT_FALLBACK && throttle_out == '0 && steering_out == '0)
    else $error("stale command without zeroed fallback");

  a_pass_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OUT_PASSED |-> violation_code == CODE_NONE)
    else $error("passed result carries a violation");

  a_rate_fallback: assert property (@(posedge clk) disable iff (rst)
    out_valid && (violation_code == CODE_T_RATE || violation_code == CODE_S_RATE) |->
      outcome == OUT_FALLBACK)
    else $error("rate violation without fallback");

endmodule

bind command_safety_limiter_unit csl_checker u_csl_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .outcome        (outcome),
  .violation_code (violation_code),
  .throttle_out   (throttle_out),
  .steering_out   (steering_out)
);
`default_nettype wire
